### sv/deadline_ordered_wait_queue_defines.svh
// ---------------------------------------------------------------------------
// Deadline-ordered wait queue assertion macros
// Shared assertion forms, clocked on clk_i and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef DEADLINE_ORDERED_WAIT_QUEUE_DEFINES_SVH
`define DEADLINE_ORDERED_WAIT_QUEUE_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define DOWQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define DOWQ_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

### sv/dowq_pkg.sv
// ---------------------------------------------------------------------------
// Deadline-ordered wait queue package
// Sizes, codes, slot entry type and the control structs of the queue.
// ---------------------------------------------------------------------------
package dowq_pkg;

  localparam int unsigned QueueDepth  = 8;
  localparam int unsigned PrioBits    = 32;
  localparam int unsigned IdBits      = 8;
  localparam int unsigned IdxBits     = $clog2(QueueDepth);
  localparam int unsigned CntBits     = $clog2(QueueDepth + 1);
  localparam int unsigned CmdBits     = 2;
  localparam int unsigned StatusBits  = 2;
  localparam int unsigned CapBits     = 4;
  localparam int unsigned CapReset    = 8;
  localparam int unsigned ApbAddrBits = 3;
  localparam int unsigned ApbDataBits = 32;

  typedef enum logic [CmdBits-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_APPEND = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [StatusBits-1:0] {
    STAT_DONE      = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_e;

  typedef enum logic [0:0] {
    REG_MODE     = 1'b0,
    REG_CAPACITY = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [IdBits-1:0]   id;
    logic [PrioBits-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic               en;
    logic [IdxBits-1:0] addr;
    entry_t             data;
  } slot_wr_t;

  typedef struct packed {
    logic served_before;
    logic id_match;
  } cmp_t;

endpackage

### sv/dowq_req_if.sv
// ---------------------------------------------------------------------------
// Deadline-ordered wait queue request channel
// Valid/ready channel carrying one queue command.
// ---------------------------------------------------------------------------
interface dowq_req_if import dowq_pkg::*;;

  logic                  valid;
  logic                  ready;
  logic [CmdBits-1:0]    command;
  logic [IdBits-1:0]     entry_id;
  logic [PrioBits-1:0]   entry_priority;

  modport source (output valid, output command, output entry_id, output entry_priority,
                  input ready);
  modport sink   (input valid, input command, input entry_id, input entry_priority,
                  output ready);

endinterface

### sv/dowq_rsp_if.sv
// ---------------------------------------------------------------------------
// Deadline-ordered wait queue response channel
// Valid/ready channel carrying the status and front entry after a request.
// ---------------------------------------------------------------------------
interface dowq_rsp_if import dowq_pkg::*;;

  logic                  valid;
  logic                  ready;
  logic [StatusBits-1:0] status;
  logic                  head_valid;
  logic [IdBits-1:0]     head_id;
  logic [PrioBits-1:0]   head_priority;
  logic [CntBits-1:0]    occupancy;

  modport source (output valid, output status, output head_valid, output head_id,
                  output head_priority, output occupancy, input ready);
  modport sink   (input valid, input status, input head_valid, input head_id,
                  input head_priority, input occupancy, output ready);

endinterface

### sv/dowq_store.sv
// ---------------------------------------------------------------------------
// Deadline-ordered wait queue slot store
// Slot registers with one write port, one selectable read port, the front
// slot tap and the single shared comparator used by the sequencer.
// ---------------------------------------------------------------------------
module dowq_store import dowq_pkg::*; (
  input  logic               clk_i,
  input  slot_wr_t           wr_i,
  input  logic [IdxBits-1:0] rd_addr_i,
  input  entry_t             key_i,
  output entry_t             rd_data_o,
  output entry_t             head_o,
  output cmp_t               cmp_o
);

  entry_t slots_q [QueueDepth];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      slots_q[wr_i.addr] <= wr_i.data;
    end
  end

  assign rd_data_o = slots_q[rd_addr_i];
  assign head_o    = slots_q[0];

  // A held entry is served first on a smaller priority, or on a tie when its id
  // is not smaller than that of the new entry.
  always_comb begin
    if (rd_data_o.prio != key_i.prio) begin
      cmp_o.served_before = rd_data_o.prio < key_i.prio;
    end else begin
      cmp_o.served_before = rd_data_o.id >= key_i.id;
    end
    cmp_o.id_match = rd_data_o.id == key_i.id;
  end

endmodule

### sv/deadline_ordered_wait_queue.sv
// ---------------------------------------------------------------------------
// Deadline-ordered wait queue
// Small queue of (id, priority) entries with ordered insert and remove by id.
// ---------------------------------------------------------------------------
// A request is taken only while the sequencer is idle and then walks the slots
// one per cycle through a single read port and one shared comparator.
// A refused push, a remove on an empty queue or an unused command goes
// straight to the final step. A push in arrival order writes its entry at the
// tail; an ordered push first moves each entry it passes one slot back. A
// remove scans from the back up to and including the slot with its id and
// then moves the later entries forward to close the gap; a remove that finds
// nothing on a non-empty queue scans every held entry. The final step waits
// while the previous response is still held and not taken. The response sits
// in an output register, so a new request is accepted while the previous
// response waits to be taken.
`include "deadline_ordered_wait_queue_defines.svh"

module deadline_ordered_wait_queue import dowq_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  dowq_req_if.sink               req_i,
  dowq_rsp_if.source             rsp_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ApbAddrBits-1:0] paddr,
  input  logic [ApbDataBits-1:0] pwdata,
  output logic [ApbDataBits-1:0] prdata,
  output logic                   pready
);

  state_e                state_q, state_d;
  logic [CntBits-1:0]    cnt_q, cnt_d;
  logic [IdxBits-1:0]    ptr_q, ptr_d;
  entry_t                key_q, key_d;
  logic                  ordered_q, ordered_d;
  status_e               status_q, status_d;
  logic                  mode_q;
  logic [CapBits-1:0]    cap_q;

  logic                  out_valid_q, out_valid_d;
  status_e               out_status_q, out_status_d;
  logic                  out_head_valid_q, out_head_valid_d;
  entry_t                out_head_q, out_head_d;
  logic [CntBits-1:0]    out_cnt_q, out_cnt_d;

  slot_wr_t              slot_wr;
  logic [IdxBits-1:0]    rd_addr;
  entry_t                rd_data;
  entry_t                head;
  cmp_t                  cmp;

  logic                  accept;
  logic                  cfg_write;
  reg_idx_e              cfg_idx;
  cmd_e                  cmd;
  logic                  full;
  logic                  walk_stop;
  logic                  shift_more;
  logic                  out_free;

  dowq_store u_store (
    .clk_i     (clk_i),
    .wr_i      (slot_wr),
    .rd_addr_i (rd_addr),
    .key_i     (key_q),
    .rd_data_o (rd_data),
    .head_o    (head),
    .cmp_o     (cmp)
  );

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_e'(paddr[2]);

  always_comb begin
    case (cfg_idx)
      REG_MODE:     prdata = ApbDataBits'(mode_q);
      REG_CAPACITY: prdata = ApbDataBits'(cap_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      cap_q  <= CapBits'(CapReset);
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_MODE:     mode_q <= pwdata[0];
        REG_CAPACITY: cap_q  <= pwdata[CapBits-1:0];
        default:      ;
      endcase
    end
  end

  // Shared conditions.
  assign req_i.ready = state_q == S_IDLE;
  assign accept      = req_i.valid && req_i.ready;
  assign cmd         = cmd_e'(req_i.command);
  assign full        = ((CapBits + CntBits)'(cnt_q) >= (CapBits + CntBits)'(cap_q)) ||
                       (cnt_q >= CntBits'(QueueDepth));
  assign walk_stop   = !ordered_q || (ptr_q == '0) || cmp.served_before;
  assign shift_more  = (CntBits'(ptr_q) + CntBits'(1)) < cnt_q;
  assign out_free    = !out_valid_q || rsp_o.ready;

  always_comb begin
    case (state_q)
      S_INSERT: rd_addr = ptr_q - IdxBits'(1);
      S_SHIFT:  rd_addr = ptr_q + IdxBits'(1);
      default:  rd_addr = ptr_q;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_PUSH, CMD_APPEND: state_d = full ? S_FINISH : S_INSERT;
            CMD_REMOVE:           state_d = (cnt_q == '0) ? S_FINISH : S_SCAN;
            default:              state_d = S_FINISH;
          endcase
        end
      end
      S_INSERT: begin
        if (walk_stop) begin
          state_d = S_FINISH;
        end
      end
      S_SCAN: begin
        if (cmp.id_match) begin
          state_d = S_SHIFT;
        end else if (ptr_q == '0) begin
          state_d = S_FINISH;
        end
      end
      S_SHIFT: begin
        if (!shift_more) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cnt_d            = cnt_q;
    ptr_d            = ptr_q;
    key_d            = key_q;
    ordered_d        = ordered_q;
    status_d         = status_q;
    slot_wr          = '0;
    out_valid_d      = out_valid_q && !rsp_o.ready;
    out_status_d     = out_status_q;
    out_head_valid_d = out_head_valid_q;
    out_head_d       = out_head_q;
    out_cnt_d        = out_cnt_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d.id   = req_i.entry_id;
          key_d.prio = req_i.entry_priority;
          ordered_d  = (cmd == CMD_PUSH) && mode_q;
          status_d   = STAT_DONE;
          case (cmd)
            CMD_PUSH, CMD_APPEND: begin
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                ptr_d = cnt_q[IdxBits-1:0];
              end
            end
            CMD_REMOVE: begin
              if (cnt_q == '0) begin
                status_d = STAT_NOT_FOUND;
              end else begin
                ptr_d = IdxBits'(cnt_q - CntBits'(1));
              end
            end
            default: ;
          endcase
        end
      end
      S_INSERT: begin
        slot_wr.en   = 1'b1;
        slot_wr.addr = ptr_q;
        if (walk_stop) begin
          slot_wr.data = key_q;
          cnt_d        = cnt_q + CntBits'(1);
        end else begin
          slot_wr.data = rd_data;
          ptr_d        = ptr_q - IdxBits'(1);
        end
      end
      S_SCAN: begin
        if (!cmp.id_match) begin
          if (ptr_q == '0) begin
            status_d = STAT_NOT_FOUND;
          end else begin
            ptr_d = ptr_q - IdxBits'(1);
          end
        end
      end
      S_SHIFT: begin
        if (shift_more) begin
          slot_wr.en   = 1'b1;
          slot_wr.addr = ptr_q;
          slot_wr.data = rd_data;
          ptr_d        = ptr_q + IdxBits'(1);
        end else begin
          cnt_d = cnt_q - CntBits'(1);
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_status_d     = status_q;
          out_head_valid_d = cnt_q != '0;
          out_head_d       = (cnt_q != '0) ? head : '0;
          out_cnt_d        = cnt_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q            <= ptr_d;
    key_q            <= key_d;
    ordered_q        <= ordered_d;
    status_q         <= status_d;
    out_status_q     <= out_status_d;
    out_head_valid_q <= out_head_valid_d;
    out_head_q       <= out_head_d;
    out_cnt_q        <= out_cnt_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.head_valid    = out_head_valid_q;
  assign rsp_o.head_id       = out_head_q.id;
  assign rsp_o.head_priority = out_head_q.prio;
  assign rsp_o.occupancy     = out_cnt_q;

  `DOWQ_ASSERT(a_cnt_bound, cnt_q <= CntBits'(QueueDepth), "Occupancy beyond the queue depth.")
  `DOWQ_ASSERT(a_accept_busy, accept |=> (state_q != S_IDLE), "Accepted request was not started.")
  `DOWQ_ASSERT(a_insert_ptr, (state_q == S_INSERT) |-> (CntBits'(ptr_q) <= cnt_q), "Insert past the tail.")
  `DOWQ_ASSERT(a_scan_ptr, (state_q == S_SCAN) |-> (CntBits'(ptr_q) < cnt_q), "Scan outside held entries.")
  `DOWQ_ASSERT(a_finish_load, (state_q == S_FINISH && out_free) |=> rsp_o.valid, "Response not presented.")
  `DOWQ_ASSERT_NEVER(a_cnt_step, (cnt_q != $past(cnt_q)) && ($past(state_q) != S_INSERT) && ($past(state_q) != S_SHIFT), "Occupancy changed outside insert or shift.")

endmodule
